@@ hdl/mwm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel mixer package
// Shared constants, register indexes and control word types of the mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

   localparam int unsigned FRAC_BITS_DEF = 14;
   localparam int unsigned CMD_W         = 16;
   localparam int unsigned DB_W          = 14;

   localparam logic [DB_W-1:0] TRANS_DB_RST = 14'd819;
   localparam logic [DB_W-1:0] ROT_DB_RST   = 14'd1638;

   typedef enum logic {
      CSR_TRANS_DB = 1'b0,
      CSR_ROT_DB   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic       shape;
      logic [2:0] neg;
      logic [2:0] zero;
   } axis_ctl_type;

   typedef struct packed {
      logic       big;
      logic [3:0] neg;
   } norm_ctl_type;

endpackage
`default_nettype wire

@@ hdl/mwm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides (num << (QW-1)) by den over QW stages, one quotient bit per stage,
// for several lanes at once; num must not exceed den.
// ----------------------------------------------------------------------------
module mwm_div #(
   parameter int unsigned DW    = 16,
   parameter int unsigned QW    = 15,
   parameter int unsigned LANES = 3,
   parameter int unsigned SBW   = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  logic [LANES-1:0][DW-1:0]      in_num,
   input  logic [LANES-1:0][DW-1:0]      in_den,
   input  logic [SBW-1:0]                in_sb,
   output logic                          out_valid,
   output logic [LANES-1:0][QW-1:0]      out_quo,
   output logic [SBW-1:0]                out_sb
);

   logic [QW-1:0]                 vld_ff;
   logic [LANES-1:0][DW-1:0]      rem_ff [QW];
   logic [LANES-1:0][DW-1:0]      den_ff [QW];
   logic [LANES-1:0][QW-1:0]      quo_ff [QW];
   logic [SBW-1:0]                sb_ff  [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic                       p_vld;
      logic [LANES-1:0][DW-1:0]   p_rem;
      logic [LANES-1:0][DW-1:0]   p_den;
      logic [LANES-1:0][QW-1:0]   p_quo;
      logic [LANES-1:0]           p_bit;
      logic [SBW-1:0]             p_sb;
      logic [LANES-1:0][DW-1:0]   rem_in;
      logic [LANES-1:0][QW-1:0]   quo_in;

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               p_rem[l] = in_num[l] >> 1;
               p_bit[l] = in_num[l][0];
            end
         end
         assign p_vld = in_valid;
         assign p_den = in_den;
         assign p_quo = '0;
         assign p_sb  = in_sb;
      end else begin : g_next
         assign p_vld = vld_ff[s-1];
         assign p_rem = rem_ff[s-1];
         assign p_bit = '0;
         assign p_den = den_ff[s-1];
         assign p_quo = quo_ff[s-1];
         assign p_sb  = sb_ff[s-1];
      end

      always_comb begin
         logic [DW:0] trial;
         for (int l = 0; l < LANES; l++) begin
            trial = {p_rem[l], p_bit[l]};
            if (trial >= {1'b0, p_den[l]}) begin
               rem_in[l] = DW'(trial - {1'b0, p_den[l]});
               quo_in[l] = {p_quo[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = trial[DW-1:0];
               quo_in[l] = {p_quo[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (ce) begin
            vld_ff[s] <= p_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= p_den;
            quo_ff[s] <= quo_in;
            sb_ff[s]  <= p_sb;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_sb    = sb_ff[QW-1];

`ifndef SYNTH
   for (genvar l = 0; l < LANES; l++) begin : g_chk
      a_quo_range: assert property (@(posedge clock) disable iff (reset)
         out_valid |-> (out_quo[l] <= (QW'(1) << (QW-1))))
         else $error("Divider quotient exceeds one.");
   end
`endif

endmodule
`default_nettype wire

@@ hdl/mwm_mix.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Wheel mixer stages
// Rebuilds the shaped or raw axes, forms the four wheel sums and finds the largest
// wheel magnitude for normalisation.
// ----------------------------------------------------------------------------
module mwm_mix import mwm_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
   parameter int unsigned AW        = 17,
   parameter int unsigned QW        = 15,
   parameter int unsigned SW        = 19
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ce,
   input  logic                        in_valid,
   input  logic [2:0][QW-1:0]          in_quo,
   input  axis_ctl_type                in_ctl,
   input  logic [2:0][AW-1:0]          in_raw,
   output logic                        out_valid,
   output logic [3:0][SW-2:0]          out_num,
   output logic [SW-2:0]               out_den,
   output norm_ctl_type                out_ctl,
   output logic [3:0][SW-1:0]          out_sum
);

   localparam logic [SW-2:0] ONE_N = (SW-1)'(1) << FRAC_BITS;

   logic [2:0][AW-1:0]  axis;
   logic [3:0][SW-1:0]  sum_in;
   logic [3:0][SW-1:0]  suma_ff;
   logic                va_ff;
   logic [3:0][SW-2:0]  mag;
   logic [3:0]          neg;
   logic [SW-2:0]       mx01;
   logic [SW-2:0]       mx23;
   logic [SW-2:0]       mx;
   logic [3:0][SW-2:0]  num_ff;
   logic [SW-2:0]       den_ff;
   norm_ctl_type        ctl_ff;
   logic [3:0][SW-1:0]  sumb_ff;
   logic                vb_ff;

   always_comb begin
      logic signed [SW-1:0] d;
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] r;
      for (int l = 0; l < 3; l++) begin
         if (!in_ctl.shape) begin
            axis[l] = in_raw[l];
         end else if (in_ctl.zero[l]) begin
            axis[l] = '0;
         end else if (in_ctl.neg[l]) begin
            axis[l] = AW'(0) - AW'(in_quo[l]);
         end else begin
            axis[l] = AW'(in_quo[l]);
         end
      end
      d = SW'($signed(axis[0]));
      s = SW'($signed(axis[1]));
      r = SW'($signed(axis[2]));
      sum_in[0] = r + d + s;
      sum_in[1] = r + d - s;
      sum_in[2] = r - d + s;
      sum_in[3] = r - d - s;
   end

   always_comb begin
      logic [SW-1:0] t;
      for (int l = 0; l < 4; l++) begin
         neg[l] = suma_ff[l][SW-1];
         t      = neg[l] ? (~suma_ff[l] + 1'b1) : suma_ff[l];
         mag[l] = t[SW-2:0];
      end
      mx01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
      mx23 = (mag[2] > mag[3]) ? mag[2] : mag[3];
      mx   = (mx01 > mx23) ? mx01 : mx23;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (ce) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         suma_ff    <= sum_in;
         num_ff     <= mag;
         den_ff     <= (mx == '0) ? (SW-1)'(1) : mx;
         ctl_ff.big <= mx > ONE_N;
         ctl_ff.neg <= neg;
         sumb_ff    <= suma_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_ctl   = ctl_ff;
   assign out_sum   = sumb_ff;

`ifndef SYNTH
   a_big_den: assert property (@(posedge clock) disable iff (reset)
      (vb_ff && ctl_ff.big) |-> (den_ff > ONE_N))
      else $error("Normalising divisor not above one.");
`endif

endmodule
`default_nettype wire

@@ hdl/mecanum_wheel_mixer_top.sv @@
// Path: a request word passes the input, magnitude and deadband registers, the
// shaping divider, the mixer stages, the normalising divider and the output register.
// Throughput: one word per cycle unless rsp_tready stalls; two bit-per-stage dividers.
// Reset is synchronous and active high; it clears all valid bits and loads
// the deadband registers with 819 and 1638.
`default_nettype none
// ----------------------------------------------------------------------------
// Mecanum wheel mixer top level
// Shapes drive, strafe and rotate commands and mixes them into four wheel
// drive values, normalised by the largest wheel magnitude when that exceeds one.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_top import mwm_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,   // drive_cmd, strafe_cmd, rotate_cmd
   input  logic [0:0]       req_tuser,   // shape_enable
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,   // left_front, left_rear, right_front, right_rear
   input  logic             csr_we,
   input  logic [0:0]       csr_index,
   input  logic [DB_W-1:0]  csr_wdata
);

   localparam int unsigned AW    = (FRAC_BITS + 2 > 17) ? FRAC_BITS + 2 : 17;
   localparam int unsigned MW    = AW - 1;
   localparam int unsigned SW    = AW + 2;
   localparam int unsigned QW    = FRAC_BITS + 1;
   localparam int unsigned SB1W  = $bits(axis_ctl_type) + 3 * AW;
   localparam int unsigned SB2W  = $bits(norm_ctl_type) + 4 * SW;

   localparam logic signed [AW-1:0] ONE_S   = AW'(1) <<< FRAC_BITS;
   localparam logic [MW-1:0]        ONE_M   = MW'(1) << FRAC_BITS;
   localparam logic signed [SW-1:0] OUT_MAX = SW'(32767);
   localparam logic signed [SW-1:0] OUT_MIN = -SW'(32768);
   localparam logic signed [SW-1:0] LIM     = (FRAC_BITS < 15) ? SW'(1) <<< FRAC_BITS
                                                               : SW'(32767);

   logic                    ce;
   logic [DB_W-1:0]         trans_db_ff;
   logic [DB_W-1:0]         rot_db_ff;

   logic                    v0_ff;
   logic [2:0][CMD_W-1:0]   cmd0_ff;
   logic                    shape0_ff;

   logic [2:0][MW-1:0]      mag1_in;
   logic [2:0]              neg1_in;
   logic [2:0][AW-1:0]      raw1_in;
   logic                    v1_ff;
   logic [2:0][MW-1:0]      mag1_ff;
   logic [2:0]              neg1_ff;
   logic [2:0][AW-1:0]      raw1_ff;
   logic                    shape1_ff;

   logic [2:0][MW-1:0]      num2_in;
   logic [2:0][MW-1:0]      den2_in;
   logic [2:0]              zero2_in;
   logic                    v2_ff;
   logic [2:0][MW-1:0]      num2_ff;
   logic [2:0][MW-1:0]      den2_ff;
   axis_ctl_type            ctl2_ff;
   logic [2:0][AW-1:0]      raw2_ff;

   logic                    d1_valid;
   logic [2:0][QW-1:0]      d1_quo;
   logic [SB1W-1:0]         d1_sb;
   axis_ctl_type            d1_ctl;
   logic [2:0][AW-1:0]      d1_raw;

   logic                    m_valid;
   logic [3:0][SW-2:0]      m_num;
   logic [SW-2:0]           m_den;
   norm_ctl_type            m_ctl;
   logic [3:0][SW-1:0]      m_sum;

   logic                    d2_valid;
   logic [3:0][QW-1:0]      d2_quo;
   logic [SB2W-1:0]         d2_sb;
   norm_ctl_type            d2_ctl;
   logic [3:0][SW-1:0]      d2_sum;

   logic [3:0][CMD_W-1:0]   wheel_in;
   logic                    rsp_tvalid_ff;
   logic [3:0][CMD_W-1:0]   wheel_ff;

   assign ce         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_db_ff <= TRANS_DB_RST;
         rot_db_ff   <= ROT_DB_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_TRANS_DB: trans_db_ff <= csr_wdata;
            CSR_ROT_DB:   rot_db_ff   <= csr_wdata;
            default:      trans_db_ff <= trans_db_ff;
         endcase
      end
   end

   // Strafe is negated and every axis clamped to one in joystick mode.
   always_comb begin
      logic signed [AW-1:0] x;
      for (int l = 0; l < 3; l++) begin
         raw1_in[l] = AW'($signed(cmd0_ff[l]));
         x          = raw1_in[l];
         if (shape0_ff) begin
            if (l == 1) begin
               x = -x;
            end
            if (x > ONE_S) begin
               x = ONE_S;
            end else if (x < -ONE_S) begin
               x = -ONE_S;
            end
         end
         neg1_in[l] = x[AW-1];
         mag1_in[l] = x[AW-1] ? MW'(-x) : MW'(x);
      end
   end

   // In bypass mode the divider is fed zero, as its quotient is not used.
   always_comb begin
      logic [MW-1:0] d;
      for (int l = 0; l < 3; l++) begin
         d           = (l == 2) ? MW'(rot_db_ff) : MW'(trans_db_ff);
         zero2_in[l] = !shape1_ff || (d >= ONE_M) || (mag1_ff[l] < d);
         num2_in[l]  = zero2_in[l] ? '0 : mag1_ff[l] - d;
         den2_in[l]  = zero2_in[l] ? MW'(1) : ONE_M - d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (ce) begin
         v0_ff         <= req_tvalid;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         rsp_tvalid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         cmd0_ff       <= req_tdata;
         shape0_ff     <= req_tuser[0];
         mag1_ff       <= mag1_in;
         neg1_ff       <= neg1_in;
         raw1_ff       <= raw1_in;
         shape1_ff     <= shape0_ff;
         num2_ff       <= num2_in;
         den2_ff       <= den2_in;
         ctl2_ff.shape <= shape1_ff;
         ctl2_ff.neg   <= neg1_ff;
         ctl2_ff.zero  <= zero2_in;
         raw2_ff       <= raw1_ff;
         wheel_ff      <= wheel_in;
      end
   end

   mwm_div #(
      .DW    (MW),
      .QW    (QW),
      .LANES (3),
      .SBW   (SB1W)
   ) u_shape_div (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (v2_ff),
      .in_num    (num2_ff),
      .in_den    (den2_ff),
      .in_sb     ({ctl2_ff, raw2_ff}),
      .out_valid (d1_valid),
      .out_quo   (d1_quo),
      .out_sb    (d1_sb)
   );

   assign {d1_ctl, d1_raw} = d1_sb;

   mwm_mix #(
      .FRAC_BITS (FRAC_BITS),
      .AW        (AW),
      .QW        (QW),
      .SW        (SW)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (d1_valid),
      .in_quo    (d1_quo),
      .in_ctl    (d1_ctl),
      .in_raw    (d1_raw),
      .out_valid (m_valid),
      .out_num   (m_num),
      .out_den   (m_den),
      .out_ctl   (m_ctl),
      .out_sum   (m_sum)
   );

   mwm_div #(
      .DW    (SW - 1),
      .QW    (QW),
      .LANES (4),
      .SBW   (SB2W)
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (m_valid),
      .in_num    (m_num),
      .in_den    ({4{m_den}}),
      .in_sb     ({m_ctl, m_sum}),
      .out_valid (d2_valid),
      .out_quo   (d2_quo),
      .out_sb    (d2_sb)
   );

   assign {d2_ctl, d2_sum} = d2_sb;

   always_comb begin
      logic signed [SW-1:0] v;
      for (int l = 0; l < 4; l++) begin
         if (!d2_ctl.big) begin
            v = d2_sum[l];
         end else if (d2_ctl.neg[l]) begin
            v = SW'(0) - SW'(d2_quo[l]);
         end else begin
            v = SW'(d2_quo[l]);
         end
         if (v > OUT_MAX) begin
            v = OUT_MAX;
         end else if (v < OUT_MIN) begin
            v = OUT_MIN;
         end
         wheel_in[l] = v[CMD_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = wheel_ff;

`ifndef SYNTH
   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(SW'($signed(wheel_ff[0]))) <= LIM) &&
         ($signed(SW'($signed(wheel_ff[0]))) >= -LIM) &&
         ($signed(SW'($signed(wheel_ff[1]))) <= LIM) &&
         ($signed(SW'($signed(wheel_ff[1]))) >= -LIM) &&
         ($signed(SW'($signed(wheel_ff[2]))) <= LIM) &&
         ($signed(SW'($signed(wheel_ff[2]))) >= -LIM) &&
         ($signed(SW'($signed(wheel_ff[3]))) <= LIM) &&
         ($signed(SW'($signed(wheel_ff[3]))) >= -LIM))
      else $error("Wheel word outside the drive range.");
   a_shape_num: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (num2_ff[0] <= den2_ff[0]) && (num2_ff[1] <= den2_ff[1]) &&
                (num2_ff[2] <= den2_ff[2]))
      else $error("Deadband rescale numerator exceeds divisor.");
`endif

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mecanum wheel mixer testbench
// Drives command words through the mixer under random idling on both sides,
// predicts each set of wheel values and compares it with the response word.
// ----------------------------------------------------------------------------
module testbench;
   import mwm_pkg::*;

   localparam int ONE = 1 << FRAC_BITS_DEF;
   localparam int LIMIT = 400000;

   logic clock, reset;
   logic req_tvalid, req_tready, rsp_tvalid, rsp_tready, csr_we;
   logic [47:0] req_tdata;
   logic [0:0] req_tuser;
   logic [63:0] rsp_tdata;
   logic [0:0] csr_index;
   logic [DB_W-1:0] csr_wdata;

   logic [DB_W-1:0] trans_db, rot_db;
   logic [63:0] wheel_queue[$];
   int errors, cycles;
   bit quiet;

   mecanum_wheel_mixer_top dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic longint shape(longint x, longint d);
      longint m, r;
      if (x > ONE) x = ONE;
      if (x < -ONE) x = -ONE;
      m = x < 0 ? -x : x;
      if (d >= ONE || m < d) return 0;
      r = ((m - d) * ONE) / (ONE - d);
      return x < 0 ? -r : r;
   endfunction

   function automatic logic [63:0] mix_wheels(logic [47:0] cmd, logic shp);
      longint drv, str, rot, mx, a, v;
      longint w[4];
      logic [63:0] res;
      drv = longint'($signed(cmd[15:0]));
      str = longint'($signed(cmd[31:16]));
      rot = longint'($signed(cmd[47:32]));
      if (shp) begin
         drv = shape(drv, trans_db);
         str = shape(-str, trans_db);
         rot = shape(rot, rot_db);
      end
      w[0] = rot + drv + str;
      w[1] = rot + drv - str;
      w[2] = rot - drv + str;
      w[3] = rot - drv - str;
      mx = 0;
      foreach (w[i]) begin
         a = w[i] < 0 ? -w[i] : w[i];
         if (a > mx) mx = a;
      end
      foreach (w[i]) begin
         v = w[i];
         if (mx > ONE) begin
            v = (w[i] * ONE) / mx;
            if (v > ONE) v = ONE;
            if (v < -ONE) v = -ONE;
         end
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         res[i*16 +: 16] = v[15:0];
      end
      return res;
   endfunction

   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic send_word(logic [15:0] drv, logic [15:0] str, logic [15:0] rot, logic shp);
      idle_gap();
      req_tvalid <= 1;
      req_tdata <= {rot, str, drv};
      req_tuser <= shp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      wheel_queue.push_back(mix_wheels({rot, str, drv}, shp));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (wheel_queue.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [DB_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_TRANS_DB) trans_db = val;
      else rot_db = val;
      @(negedge clock);
   endtask

   task automatic test_directed();
      logic [15:0] v[8] = '{16'h8000, 16'h7fff, 16'h0000, 16'h4000, 16'hc000,
                            16'h0333, 16'h0332, 16'hffff};
      for (int i = 0; i < 8; i++) begin
         send_word(v[i], v[(i + 3) % 8], v[(i + 5) % 8], i[0]);
         send_word(v[i], v[i], v[i], ~i[0]);
      end
      send_word(16'h0666, 16'hf99a, 16'h0665, 1);
      send_word(16'h4000, 16'h4000, 16'h4000, 0);
   endtask

   task automatic test_random(int count);
      logic [15:0] a[3];
      for (int n = 0; n < count; n++) begin
         foreach (a[k])
            case ($urandom_range(0, 3))
               0: a[k] = 16'($urandom);
               1: a[k] = 16'($urandom_range(0, 2 * ONE) - ONE);
               2: a[k] = 16'($urandom_range(0, 2000) - 1000);
               default: a[k] = 16'($urandom_range(0, 600) - 300 +
                                   ((ONE / 2) * $urandom_range(0, 2) - ONE / 2));
            endcase
         send_word(a[0], a[1], a[2], 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_deadbands();
      logic [DB_W-1:0] s[4] = '{14'd0, 14'h3fff, 14'd8192, 14'd100};
      foreach (s[i]) begin
         drain();
         write_reg(CSR_TRANS_DB, s[i]);
         write_reg(CSR_ROT_DB, s[3 - i]);
         test_random(60);
      end
      drain();
      write_reg(CSR_TRANS_DB, DB_W'($urandom));
      write_reg(CSR_ROT_DB, DB_W'($urandom));
      test_random(80);
   endtask

   initial begin
      logic [63:0] want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (wheel_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("Unexpected response word %h", rsp_tdata);
            end else begin
               want = wheel_queue.pop_front();
               for (int i = 0; i < 4; i++)
                  if (rsp_tdata[i*16 +: 16] !== want[i*16 +: 16]) begin
                     errors++;
                     if (errors <= 10)
                        $display("Wheel %0d: expected %h, got %h", i,
                                 want[i*16 +: 16], rsp_tdata[i*16 +: 16]);
                  end
            end
         end
      end
   end

   initial begin
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_tready <= 1;
      end
   end

   initial begin
      @(posedge clock);
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      trans_db = TRANS_DB_RST;
      rot_db = ROT_DB_RST;
      repeat (9) @(negedge clock);
      reset = 0;
      test_directed();
      test_random(200);
      test_deadbands();
      quiet = 1;
      test_random(60);
      drain();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

@@ files.f @@
hdl/mwm_pkg.sv
hdl/mwm_div.sv
hdl/mwm_mix.sv
hdl/mecanum_wheel_mixer_top.sv
verif/testbench.sv
